/* sv/m3i_pkg.sv */
package m3i_pkg;

  // Datapath widths
  localparam int ELEM_W  = 32;
  localparam int PROD_W  = 64;
  localparam int COF_W   = 65;
  localparam int PART_W  = 65;
  localparam int DET_W   = 99;
  localparam int DMAG_W  = 98;
  localparam int Q_W     = 32;
  localparam int CMP_W   = DMAG_W + Q_W + 1;
  localparam int N_ELEM  = 9;
  localparam int N_EXP   = 3;
  localparam int DIV_STG = Q_W + 1;

  // Pipeline depth from accepted item to result strobe
  localparam int FRONT_LAT = 6;
  localparam int LATENCY   = FRONT_LAT + 1 + DIV_STG + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] in_e0;
    logic signed [ELEM_W-1:0] in_e1;
    logic signed [ELEM_W-1:0] in_e2;
    logic signed [ELEM_W-1:0] in_e3;
    logic signed [ELEM_W-1:0] in_e4;
    logic signed [ELEM_W-1:0] in_e5;
    logic signed [ELEM_W-1:0] in_e6;
    logic signed [ELEM_W-1:0] in_e7;
    logic signed [ELEM_W-1:0] in_e8;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_e0;
    logic signed [ELEM_W-1:0] out_e1;
    logic signed [ELEM_W-1:0] out_e2;
    logic signed [ELEM_W-1:0] out_e3;
    logic signed [ELEM_W-1:0] out_e4;
    logic signed [ELEM_W-1:0] out_e5;
    logic signed [ELEM_W-1:0] out_e6;
    logic signed [ELEM_W-1:0] out_e7;
    logic signed [ELEM_W-1:0] out_e8;
    logic signed [63:0]       det_value;
    status_t                  status_code;
  } out_item_t;

  // What one divider lane hands to the merge stage.
  typedef struct packed {
    logic           big;
    logic           neg;
    logic [Q_W-1:0] quo;
  } lane_res_t;

  typedef logic [3:0] idx_t;

  // Cofactor k is e[a]*e[b] - e[c]*e[d].
  localparam idx_t COF_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Elements that multiply the first three cofactors in the determinant.
  localparam idx_t DET_IDX [N_EXP] = '{4'd0, 4'd3, 4'd6};

endpackage

/* sv/m3i_front.sv */
module m3i_front (
  input  logic                                 clk,
  input  m3i_pkg::in_item_t                    in_data,
  output logic signed [m3i_pkg::COF_W-1:0]     cof_o [m3i_pkg::N_ELEM],
  output logic signed [m3i_pkg::DET_W-1:0]     det_o
);

  logic signed [m3i_pkg::ELEM_W-1:0] elem    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::ELEM_W-1:0] e1_r    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::ELEM_W-1:0] e2_r    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::ELEM_W-1:0] ex3_r   [m3i_pkg::N_EXP];
  logic signed [m3i_pkg::PROD_W-1:0] pa_r    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::PROD_W-1:0] pb_r    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof3_r  [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof4_r  [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof5_r  [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof6_r  [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::PART_W-1:0] plo_r   [m3i_pkg::N_EXP];
  logic signed [m3i_pkg::PART_W-1:0] phi_r   [m3i_pkg::N_EXP];
  logic signed [m3i_pkg::DET_W-1:0]  term_r  [m3i_pkg::N_EXP];
  logic signed [m3i_pkg::DET_W-1:0]  det_r;

  assign elem = '{in_data.in_e0, in_data.in_e1, in_data.in_e2,
                  in_data.in_e3, in_data.in_e4, in_data.in_e5,
                  in_data.in_e6, in_data.in_e7, in_data.in_e8};

  // Input capture and the eighteen 32x32 cofactor products.
  always_ff @(posedge clk) begin
    for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
      e1_r[k] <= elem[k];
      e2_r[k] <= e1_r[k];
      pa_r[k] <= e1_r[m3i_pkg::COF_IDX[k][0]] * e1_r[m3i_pkg::COF_IDX[k][1]];
      pb_r[k] <= e1_r[m3i_pkg::COF_IDX[k][2]] * e1_r[m3i_pkg::COF_IDX[k][3]];
    end
  end

  // Cofactors are exact differences of the products.
  always_ff @(posedge clk) begin
    for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
      cof3_r[k] <= m3i_pkg::COF_W'(pa_r[k]) - m3i_pkg::COF_W'(pb_r[k]);
      cof4_r[k] <= cof3_r[k];
      cof5_r[k] <= cof4_r[k];
      cof6_r[k] <= cof5_r[k];
    end
    for (int j = 0; j < m3i_pkg::N_EXP; j++) begin
      ex3_r[j] <= e2_r[m3i_pkg::DET_IDX[j]];
    end
  end

  // The 65-bit cofactor times an element is split into two partial products.
  always_ff @(posedge clk) begin
    for (int j = 0; j < m3i_pkg::N_EXP; j++) begin
      plo_r[j] <= ex3_r[j] * $signed({1'b0, cof3_r[j][31:0]});
      phi_r[j] <= ex3_r[j] * $signed(cof3_r[j][m3i_pkg::COF_W-1:32]);
    end
  end

  // Recombine the partial products, then sum the three expansion terms.
  always_ff @(posedge clk) begin
    for (int j = 0; j < m3i_pkg::N_EXP; j++) begin
      term_r[j] <= (m3i_pkg::DET_W'(phi_r[j]) <<< 32) + m3i_pkg::DET_W'(plo_r[j]);
    end
    det_r <= term_r[0] + term_r[1] + term_r[2];
  end

  assign cof_o = cof6_r;
  assign det_o = det_r;

endmodule

/* sv/m3i_div_lane.sv */
module m3i_div_lane #(
  parameter int NUM_W = 97
) (
  input  logic                              clk,
  input  logic [NUM_W-1:0]                  num_i,
  input  logic                              neg_i,
  input  logic [m3i_pkg::DMAG_W-1:0]        d_i [m3i_pkg::DIV_STG],
  output m3i_pkg::lane_res_t                res_o
);

  logic [NUM_W-1:0]          r_r   [m3i_pkg::DIV_STG];
  logic [m3i_pkg::Q_W-1:0]   q_r   [m3i_pkg::DIV_STG];
  logic                      neg_r [m3i_pkg::DIV_STG];
  logic                      big_r [m3i_pkg::DIV_STG];

  // First stage: a quotient of 2^32 or more only ever saturates.
  always_ff @(posedge clk) begin
    r_r[0]   <= num_i;
    q_r[0]   <= '0;
    neg_r[0] <= neg_i;
    big_r[0] <= m3i_pkg::CMP_W'(num_i) >=
                (m3i_pkg::CMP_W'(d_i[0]) << m3i_pkg::Q_W);
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 1; j < m3i_pkg::DIV_STG; j++) begin : g_step
    logic [m3i_pkg::CMP_W-1:0] trial;
    logic [m3i_pkg::CMP_W-1:0] rem_ext;
    logic                      ge;
    logic [m3i_pkg::Q_W-1:0]   q_nxt;

    always_comb begin
      trial   = m3i_pkg::CMP_W'(d_i[j]) << (m3i_pkg::Q_W - j);
      rem_ext = m3i_pkg::CMP_W'(r_r[j-1]);
      ge      = rem_ext >= trial;
      q_nxt   = q_r[j-1];
      q_nxt[m3i_pkg::Q_W - j] = ge;
    end

    always_ff @(posedge clk) begin
      r_r[j]   <= ge ? NUM_W'(rem_ext - trial) : r_r[j-1];
      q_r[j]   <= q_nxt;
      neg_r[j] <= neg_r[j-1];
      big_r[j] <= big_r[j-1];
    end
  end

  assign res_o = '{big: big_r[m3i_pkg::DIV_STG-1],
                   neg: neg_r[m3i_pkg::DIV_STG-1],
                   quo: q_r[m3i_pkg::DIV_STG-1]};

endmodule

/* sv/m3i_merge.sv */
module m3i_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  m3i_pkg::lane_res_t             res_i [m3i_pkg::N_ELEM],
  input  logic [m3i_pkg::DMAG_W-1:0]     d_i,
  input  logic                           dneg_i,
  output m3i_pkg::out_item_t             out_o
);

  localparam logic [m3i_pkg::Q_W-1:0] Q_NEG_LIM = {1'b1, {(m3i_pkg::Q_W-1){1'b0}}};
  localparam logic [m3i_pkg::Q_W-1:0] Q_POS_LIM = {1'b0, {(m3i_pkg::Q_W-1){1'b1}}};
  localparam logic [63:0] D_NEG_LIM = {1'b1, 63'd0};
  localparam logic [63:0] D_POS_LIM = {1'b0, {63{1'b1}}};

  logic [m3i_pkg::Q_W-1:0]    elem_nxt [m3i_pkg::N_ELEM];
  logic [m3i_pkg::N_ELEM-1:0] sat;
  logic [m3i_pkg::DMAG_W-1:0] dm;
  logic [63:0]                det_nxt;
  logic                       singular;
  m3i_pkg::out_item_t         out_nxt;
  m3i_pkg::out_item_t         out_r;

  // Saturate and sign each lane's quotient.
  always_comb begin
    for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
      if (res_i[k].neg) begin
        sat[k]      = res_i[k].big || (res_i[k].quo > Q_NEG_LIM);
        elem_nxt[k] = sat[k] ? Q_NEG_LIM : (~res_i[k].quo + 1'b1);
      end else begin
        sat[k]      = res_i[k].big || res_i[k].quo[m3i_pkg::Q_W-1];
        elem_nxt[k] = sat[k] ? Q_POS_LIM : res_i[k].quo;
      end
    end
  end

  // Determinant output, truncated toward zero and saturated.
  always_comb begin
    dm       = d_i >> FRAC_BITS;
    singular = (d_i == '0);
    if (dneg_i) begin
      det_nxt = (dm > m3i_pkg::DMAG_W'(D_NEG_LIM)) ? D_NEG_LIM : (~dm[63:0] + 1'b1);
    end else begin
      det_nxt = (dm > m3i_pkg::DMAG_W'(D_POS_LIM)) ? D_POS_LIM : dm[63:0];
    end
  end

  // Merge the lanes into one result item.
  always_comb begin
    if (singular) begin
      out_nxt             = '0;
      out_nxt.status_code = m3i_pkg::ST_SINGULAR;
    end else begin
      out_nxt.out_e0      = elem_nxt[0];
      out_nxt.out_e1      = elem_nxt[1];
      out_nxt.out_e2      = elem_nxt[2];
      out_nxt.out_e3      = elem_nxt[3];
      out_nxt.out_e4      = elem_nxt[4];
      out_nxt.out_e5      = elem_nxt[5];
      out_nxt.out_e6      = elem_nxt[6];
      out_nxt.out_e7      = elem_nxt[7];
      out_nxt.out_e8      = elem_nxt[8];
      out_nxt.det_value   = det_nxt;
      out_nxt.status_code = (|sat) ? m3i_pkg::ST_SAT : m3i_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_o = out_r;

endmodule

/* sv/matrix3_inverse_adjugate_top.sv */
// 3x3 matrix inverse by the adjugate, signed fixed point.
//
// Input channel: drive in_data with nine elements and pulse start. An item
// is taken at each rising edge with start high and busy low; busy stays low,
// so a new matrix may enter every cycle.
// Result channel: out_valid is high for exactly one cycle with out_data
// holding the nine inverse elements, the determinant and a status code
// (ok, singular, or an inverse element saturated). Results leave in the
// order items came in.
// Throughput: one item per cycle. The front end forms the cofactors and
// determinant (input capture, products, cofactors, partial products, terms,
// determinant sum), a register takes magnitudes, nine divider lanes of 33
// stages each (a saturation check and one quotient bit per stage) run in
// parallel, and a last register merges the lanes and saturates.
// Reset (rst_n low, synchronous) drops every item in flight; no result
// strobes after it for those items.
// The receiver cannot stall: a result not taken in its cycle is gone.
module matrix3_inverse_adjugate_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  m3i_pkg::in_item_t   in_data,
  output logic                out_valid,
  output m3i_pkg::out_item_t  out_data
);

  localparam int NUM_W = m3i_pkg::COF_W + 2 * FRAC_BITS;

  logic signed [m3i_pkg::COF_W-1:0] cof    [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::DET_W-1:0] det;
  logic [NUM_W-1:0]                 num_r  [m3i_pkg::N_ELEM];
  logic                             cneg_r [m3i_pkg::N_ELEM];
  logic [m3i_pkg::DMAG_W-1:0]       d_r    [m3i_pkg::DIV_STG + 1];
  logic                             dneg_r [m3i_pkg::DIV_STG + 1];
  logic [m3i_pkg::DMAG_W-1:0]       d_lane [m3i_pkg::DIV_STG];
  m3i_pkg::lane_res_t               lane_res [m3i_pkg::N_ELEM];
  logic [m3i_pkg::LATENCY-1:0]      vld_r;
  logic [m3i_pkg::LATENCY-1:0]      vld_nxt;

  assign busy = 1'b0;

  // Item tracking along the pipeline.
  always_comb begin
    vld_nxt = {vld_r[m3i_pkg::LATENCY-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[m3i_pkg::LATENCY-1];

  m3i_front u_front (
    .clk     (clk),
    .in_data (in_data),
    .cof_o   (cof),
    .det_o   (det)
  );

  // Magnitudes and signs for the dividers; dividends carry 2*FRAC_BITS.
  always_ff @(posedge clk) begin
    d_r[0]    <= det[m3i_pkg::DET_W-1] ? m3i_pkg::DMAG_W'(-det) : m3i_pkg::DMAG_W'(det);
    dneg_r[0] <= det[m3i_pkg::DET_W-1];
    for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
      num_r[k]  <= (cof[k][m3i_pkg::COF_W-1] ? NUM_W'(-cof[k]) : NUM_W'(cof[k]))
                   << (2 * FRAC_BITS);
      cneg_r[k] <= cof[k][m3i_pkg::COF_W-1] ^ det[m3i_pkg::DET_W-1];
    end
  end

  // The divisor travels beside the lanes, one copy for all nine.
  always_ff @(posedge clk) begin
    for (int s = 1; s <= m3i_pkg::DIV_STG; s++) begin
      d_r[s]    <= d_r[s-1];
      dneg_r[s] <= dneg_r[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < m3i_pkg::DIV_STG; s++) begin
      d_lane[s] = d_r[s];
    end
  end

  for (genvar k = 0; k < m3i_pkg::N_ELEM; k++) begin : g_lane
    m3i_div_lane #(
      .NUM_W (NUM_W)
    ) u_lane (
      .clk   (clk),
      .num_i (num_r[k]),
      .neg_i (cneg_r[k]),
      .d_i   (d_lane),
      .res_o (lane_res[k])
    );
  end

  m3i_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .res_i  (lane_res),
    .d_i    (d_r[m3i_pkg::DIV_STG]),
    .dneg_i (dneg_r[m3i_pkg::DIV_STG]),
    .out_o  (out_data)
  );

endmodule

/* sv/m3i_checker.sv */
module m3i_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input m3i_pkg::out_item_t  out_data
);

  logic any_bound;
  logic all_zero;

  // A saturated element sits at one of the two Q16.16 limits.
  assign any_bound =
    (out_data.out_e0 == 32'sh7fffffff) || (out_data.out_e0 == 32'sh80000000) ||
    (out_data.out_e1 == 32'sh7fffffff) || (out_data.out_e1 == 32'sh80000000) ||
    (out_data.out_e2 == 32'sh7fffffff) || (out_data.out_e2 == 32'sh80000000) ||
    (out_data.out_e3 == 32'sh7fffffff) || (out_data.out_e3 == 32'sh80000000) ||
    (out_data.out_e4 == 32'sh7fffffff) || (out_data.out_e4 == 32'sh80000000) ||
    (out_data.out_e5 == 32'sh7fffffff) || (out_data.out_e5 == 32'sh80000000) ||
    (out_data.out_e6 == 32'sh7fffffff) || (out_data.out_e6 == 32'sh80000000) ||
    (out_data.out_e7 == 32'sh7fffffff) || (out_data.out_e7 == 32'sh80000000) ||
    (out_data.out_e8 == 32'sh7fffffff) || (out_data.out_e8 == 32'sh80000000);

  assign all_zero = (out_data.out_e0 == '0) && (out_data.out_e1 == '0) &&
                    (out_data.out_e2 == '0) && (out_data.out_e3 == '0) &&
                    (out_data.out_e4 == '0) && (out_data.out_e5 == '0) &&
                    (out_data.out_e6 == '0) && (out_data.out_e7 == '0) &&
                    (out_data.out_e8 == '0) && (out_data.det_value == '0);

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Every result traces back to an item taken a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, m3i_pkg::LATENCY))
    else $error("result without a matching item");

  // A singular matrix gives an all-zero result.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status_code == m3i_pkg::ST_SINGULAR) |-> all_zero)
    else $error("singular result is not zero");

  // A saturation status is backed by an element at a limit.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status_code == m3i_pkg::ST_SAT) |-> any_bound)
    else $error("saturation reported with no element at a limit");

endmodule

bind matrix3_inverse_adjugate_top m3i_checker u_m3i_checker (.*);
